@@ design/utld_pkg.sv @@
// Shared types and constants of the Unix time to local date converter.
`default_nettype none

package utld_pkg;

	// Field widths of the input and result beats.
	localparam int TS_W     = 32;
	localparam int YEAR_W   = 12;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;

	// Internal widths, set by the ranges of the intermediate values.
	localparam int DAYS_W = 16;  // whole days since the epoch, at most 49710
	localparam int SOD_W  = 17;  // seconds of the day
	localparam int SOH_W  = 12;  // seconds of the hour
	localparam int Z_W    = 20;  // days counted from the shifted epoch
	localparam int DOE_W  = 18;  // day of the 400-year era
	localparam int YOE_W  = 9;   // year of the era
	localparam int DOY_W  = 9;   // day of the March-based year
	localparam int MPN_W  = 11;  // numerator of the month estimate
	localparam int MP_W   = 4;   // March-based month index
	localparam int Q4Y_W  = 7;   // day of era over 1460
	localparam int QC_W   = 3;   // day of era over 36524

	localparam logic [TS_W-1:0]  LOCAL_OFFSET_S   = 32'd28800;
	localparam logic [TS_W-1:0]  SECS_PER_DAY     = 32'd86400;
	localparam logic [Z_W-1:0]   EPOCH_SHIFT_DAYS = 20'd719468;
	localparam logic [Z_W-1:0]   DAYS_PER_ERA     = 20'd146097;
	localparam logic [Z_W-1:0]   ERA4_START       = 20'd4 * DAYS_PER_ERA;
	localparam logic [Z_W-1:0]   ERA5_START       = 20'd5 * DAYS_PER_ERA;
	localparam logic [DOE_W-1:0] DAYS_PER_4Y      = 18'd1460;
	localparam logic [DOE_W-1:0] DAYS_PER_CENT    = 18'd36524;
	localparam logic [DOE_W-1:0] LAST_DOE         = 18'd146096;
	localparam logic [DOE_W-1:0] DAYS_PER_YEAR    = 18'd365;
	localparam logic [SOD_W-1:0] SECS_PER_HOUR    = 17'd3600;
	localparam logic [SOH_W-1:0] SECS_PER_MIN     = 12'd60;
	localparam logic [MPN_W-1:0] MP_DIV           = 11'd153;
	localparam logic [YOE_W-1:0] YOE_PER_CENT     = 9'd100;
	localparam logic [YEAR_W-1:0] YEAR_ERA4       = 12'd1600;
	localparam logic [YEAR_W-1:0] YEAR_ERA5       = 12'd2000;
	localparam logic [MP_W-1:0]  MP_JANUARY       = 4'd10;

	// Reciprocals for constant division: q = (x * floor(2^S / D)) >> S is the
	// true quotient or one less whenever x < 2^S, so one correction step fixes it.
	localparam int DAY_SHIFT  = 32;
	localparam int DOE_SHIFT  = 18;
	localparam int HOUR_SHIFT = 17;
	localparam int MIN_SHIFT  = 12;
	localparam int MP_SHIFT   = 11;

	localparam int RCP_DAY_W  = 16;
	localparam int RCP_4Y_W   = 8;
	localparam int RCP_YEAR_W = 10;
	localparam int RCP_HOUR_W = 6;
	localparam int RCP_MIN_W  = 7;
	localparam int RCP_MP_W   = 4;

	localparam logic [RCP_DAY_W-1:0] RCP_DAY =
		RCP_DAY_W'((64'd1 << DAY_SHIFT) / 64'(SECS_PER_DAY));
	localparam logic [RCP_4Y_W-1:0] RCP_4Y =
		RCP_4Y_W'((64'd1 << DOE_SHIFT) / 64'(DAYS_PER_4Y));
	localparam logic [RCP_YEAR_W-1:0] RCP_YEAR =
		RCP_YEAR_W'((64'd1 << DOE_SHIFT) / 64'(DAYS_PER_YEAR));
	localparam logic [RCP_HOUR_W-1:0] RCP_HOUR =
		RCP_HOUR_W'((64'd1 << HOUR_SHIFT) / 64'(SECS_PER_HOUR));
	localparam logic [RCP_MIN_W-1:0] RCP_MIN =
		RCP_MIN_W'((64'd1 << MIN_SHIFT) / 64'(SECS_PER_MIN));
	localparam logic [RCP_MP_W-1:0] RCP_MP =
		RCP_MP_W'((64'd1 << MP_SHIFT) / 64'(MP_DIV));

	localparam int UTLD_QUEUE_DEPTH = 4;

	// What the front hands to the back: whole local days and seconds of that day.
	typedef struct packed {
		logic [DAYS_W-1:0] days;
		logic [SOD_W-1:0]  sod;
	} day_split_t;

endpackage

`default_nettype wire

@@ design/utld_if.sv @@
// Valid/ready channel interfaces for timestamps in and calendar dates out.
`default_nettype none

interface utld_in_if import utld_pkg::*; ;
	logic            valid;
	logic            ready;
	logic [TS_W-1:0] unix_seconds;

	modport source(output valid, output unix_seconds, input ready);
	modport sink(input valid, input unix_seconds, output ready);
endinterface

interface utld_out_if import utld_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [YEAR_W-1:0]   year;
	logic [MONTH_W-1:0]  month;
	logic [DAY_W-1:0]    day;
	logic [HOUR_W-1:0]   hour;
	logic [MINUTE_W-1:0] minute;

	modport source(output valid, output year, output month, output day,
		output hour, output minute, input ready);
	modport sink(input valid, input year, input month, input day,
		input hour, input minute, output ready);
endinterface

`default_nettype wire

@@ design/utld_front.sv @@
// Front end: takes timestamp beats, applies the local offset and splits days from seconds.
`default_nettype none

module utld_front import utld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	utld_in_if.sink    stamp,
	output logic       push_valid,
	input  logic       push_ready,
	output day_split_t push_data
);

	localparam int NSTG   = 3;
	localparam int PROD_W = TS_W + RCP_DAY_W;

	logic [NSTG-1:0]     vld_q;
	logic                ce;
	logic [TS_W-1:0]     loc_s1;
	logic [TS_W-1:0]     loc_s2;
	logic [DAYS_W-1:0]   dq_s2;
	day_split_t          split_s3;
	logic [PROD_W-1:0]   day_prod;
	logic [TS_W-1:0]     day_rem;
	logic                day_fix;

	// The stages move together; they hold only while a finished split waits.
	assign ce          = !vld_q[NSTG-1] || push_ready;
	assign stamp.ready = ce;
	assign push_valid  = vld_q[NSTG-1];
	assign push_data   = split_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ce) begin
			vld_q <= {vld_q[NSTG-2:0], stamp.valid};
		end
	end

	assign day_prod = PROD_W'(loc_s1) * PROD_W'(RCP_DAY);
	assign day_rem  = loc_s2 - TS_W'(dq_s2) * SECS_PER_DAY;
	assign day_fix  = day_rem >= SECS_PER_DAY;

	always_ff @(posedge clk) begin
		if (ce) begin
			// The sum wraps at 32 bits on purpose.
			loc_s1        <= stamp.unix_seconds + LOCAL_OFFSET_S;
			loc_s2        <= loc_s1;
			dq_s2         <= day_prod[DAY_SHIFT +: DAYS_W];
			split_s3.days <= dq_s2 + DAYS_W'(day_fix);
			split_s3.sod  <= SOD_W'(day_fix ? day_rem - SECS_PER_DAY : day_rem);
		end
	end

`ifndef SYNTHESIS
	a_sod_in_day: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NSTG-1] |-> (TS_W'(split_s3.sod) < SECS_PER_DAY))
		else $error("front: seconds of day out of range");
`endif

endmodule

`default_nettype wire

@@ design/utld_queue.sv @@
// Short register queue that decouples the front end from the calendar back end.
`default_nettype none

module utld_queue import utld_pkg::*; #(
	parameter int DEPTH = UTLD_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  day_split_t push_data,
	output logic       pop_valid,
	input  logic       pop_ready,
	output day_split_t pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	day_split_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = cnt_q != CNT_W'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue: fill count beyond depth");
`endif

endmodule

`default_nettype wire

@@ design/utld_back.sv @@
// Back end: pipelined conversion of a local day count and seconds into date and time.
`default_nettype none

module utld_back import utld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  day_split_t pop_data,
	utld_out_if.source local_date
);

	localparam int NSTG = 10;

	typedef struct packed {
		logic               era5;
		logic [DOE_W-1:0]   doe;
		logic [SOD_W-1:0]   sod;
		logic [HOUR_W-1:0]  hour_est;
		logic [HOUR_W-1:0]  hour;
		logic [SOH_W-1:0]   soh;
		logic [MINUTE_W-1:0] min_est;
		logic [MINUTE_W-1:0] minute;
		logic [Q4Y_W-1:0]   q4y_est;
		logic [Q4Y_W-1:0]   q4y;
		logic [QC_W-1:0]    qcent;
		logic               last_day;
		logic [DOE_W-1:0]   yoe_num;
		logic [YOE_W-1:0]   yoe_est;
		logic [YOE_W-1:0]   yoe;
		logic [DOY_W-1:0]   doy;
		logic [MPN_W-1:0]   mp_num;
		logic [MP_W-1:0]    mp_est;
		logic [MP_W-1:0]    mp;
	} bk_t;

	typedef struct packed {
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
	} date_t;

	localparam int HPROD_W = SOD_W + RCP_HOUR_W;
	localparam int APROD_W = DOE_W + RCP_4Y_W;
	localparam int MPROD_W = SOH_W + RCP_MIN_W;
	localparam int YPROD_W = DOE_W + RCP_YEAR_W;
	localparam int PPROD_W = MPN_W + RCP_MP_W;

	// First day of each March-based month within the year.
	function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
		logic [DOY_W-1:0] r;
		unique case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	logic [NSTG-1:0] vld_q;
	logic            ce;

	bk_t   b_s1, b_s2, b_s3, b_s4, b_s5, b_s6, b_s7, b_s8, b_s9;
	bk_t   nx1, nx2, nx3, nx4, nx5, nx6, nx7, nx8, nx9;
	date_t out_s10;
	date_t nx10;

	logic [Z_W-1:0]     z;
	logic [HPROD_W-1:0] hour_prod;
	logic [SOD_W-1:0]   hour_rem;
	logic [APROD_W-1:0] q4y_prod;
	logic [DOE_W-1:0]   q4y_rem;
	logic [MPROD_W-1:0] min_prod;
	logic [SOH_W-1:0]   min_rem;
	logic [YPROD_W-1:0] yoe_prod;
	logic [DOE_W-1:0]   yoe_rem;
	logic [QC_W-1:0]    qc;
	logic [1:0]         cent;
	logic [DOE_W-1:0]   year_base;
	logic [PPROD_W-1:0] mp_prod;
	logic [MPN_W-1:0]   mp_rem;

	assign ce        = !vld_q[NSTG-1] || local_date.ready;
	assign pop_ready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ce) begin
			vld_q <= {vld_q[NSTG-2:0], pop_valid};
		end
	end

	always_comb begin
		// Stage 1: the day count of a 32-bit timestamp always lands in era 4 or 5.
		z              = Z_W'(pop_data.days) + EPOCH_SHIFT_DAYS;
		nx1            = '0;
		nx1.era5       = z >= ERA5_START;
		nx1.doe        = DOE_W'(z - (nx1.era5 ? ERA5_START : ERA4_START));
		nx1.sod        = pop_data.sod;
		hour_prod      = HPROD_W'(pop_data.sod) * HPROD_W'(RCP_HOUR);
		nx1.hour_est   = hour_prod[HOUR_SHIFT +: HOUR_W];

		// Stage 2: estimate of doe / 1460, century count, hour correction.
		nx2            = b_s1;
		q4y_prod       = APROD_W'(b_s1.doe) * APROD_W'(RCP_4Y);
		nx2.q4y_est    = q4y_prod[DOE_SHIFT +: Q4Y_W];
		qc             = '0;
		for (int k = 1; k <= 4; k++) begin
			qc = qc + QC_W'(b_s1.doe >= DOE_W'(k * DAYS_PER_CENT));
		end
		nx2.qcent      = qc;
		nx2.last_day   = b_s1.doe == LAST_DOE;
		hour_rem       = b_s1.sod - SOD_W'(b_s1.hour_est) * SECS_PER_HOUR;
		nx2.hour       = b_s1.hour_est + HOUR_W'(hour_rem >= SECS_PER_HOUR);
		nx2.soh        = SOH_W'((hour_rem >= SECS_PER_HOUR) ?
			hour_rem - SECS_PER_HOUR : hour_rem);

		// Stage 3: correct doe / 1460, estimate the minute.
		nx3            = b_s2;
		q4y_rem        = b_s2.doe - DOE_W'(b_s2.q4y_est) * DAYS_PER_4Y;
		nx3.q4y        = b_s2.q4y_est + Q4Y_W'(q4y_rem >= DAYS_PER_4Y);
		min_prod       = MPROD_W'(b_s2.soh) * MPROD_W'(RCP_MIN);
		nx3.min_est    = min_prod[MIN_SHIFT +: MINUTE_W];

		// Stage 4: leap-adjusted day of era, minute correction.
		nx4            = b_s3;
		nx4.yoe_num    = b_s3.doe - DOE_W'(b_s3.q4y) + DOE_W'(b_s3.qcent)
			- DOE_W'(b_s3.last_day);
		min_rem        = b_s3.soh - SOH_W'(b_s3.min_est) * SECS_PER_MIN;
		nx4.minute     = b_s3.min_est + MINUTE_W'(min_rem >= SECS_PER_MIN);

		// Stage 5: estimate of the year of era.
		nx5            = b_s4;
		yoe_prod       = YPROD_W'(b_s4.yoe_num) * YPROD_W'(RCP_YEAR);
		nx5.yoe_est    = yoe_prod[DOE_SHIFT +: YOE_W];

		// Stage 6: correct the year of era.
		nx6            = b_s5;
		yoe_rem        = b_s5.yoe_num - DOE_W'(b_s5.yoe_est) * DAYS_PER_YEAR;
		nx6.yoe        = b_s5.yoe_est + YOE_W'(yoe_rem >= DAYS_PER_YEAR);

		// Stage 7: day within the March-based year.
		nx7            = b_s6;
		cent           = '0;
		for (int k = 1; k <= 3; k++) begin
			cent = cent + 2'(b_s6.yoe >= YOE_W'(k * YOE_PER_CENT));
		end
		year_base      = DOE_W'(b_s6.yoe) * DAYS_PER_YEAR + DOE_W'(b_s6.yoe >> 2)
			- DOE_W'(cent);
		nx7.doy        = DOY_W'(b_s6.doe - year_base);

		// Stage 8: estimate of the March-based month.
		nx8            = b_s7;
		nx8.mp_num     = MPN_W'(b_s7.doy) * MPN_W'(5) + MPN_W'(2);
		mp_prod        = PPROD_W'(nx8.mp_num) * PPROD_W'(RCP_MP);
		nx8.mp_est     = mp_prod[MP_SHIFT +: MP_W];

		// Stage 9: correct the month.
		nx9            = b_s8;
		mp_rem         = b_s8.mp_num - MPN_W'(b_s8.mp_est) * MP_DIV;
		nx9.mp         = b_s8.mp_est + MP_W'(mp_rem >= MP_DIV);

		// Stage 10: January and February belong to the following civil year.
		nx10.year      = YEAR_W'(b_s9.yoe) + (b_s9.era5 ? YEAR_ERA5 : YEAR_ERA4)
			+ YEAR_W'(b_s9.mp >= MP_JANUARY);
		nx10.month     = (b_s9.mp < MP_JANUARY) ? b_s9.mp + MONTH_W'(3)
			: b_s9.mp - MONTH_W'(9);
		nx10.day       = DAY_W'(b_s9.doy - month_start(b_s9.mp) + DOY_W'(1));
		nx10.hour      = b_s9.hour;
		nx10.minute    = b_s9.minute;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			b_s1    <= nx1;
			b_s2    <= nx2;
			b_s3    <= nx3;
			b_s4    <= nx4;
			b_s5    <= nx5;
			b_s6    <= nx6;
			b_s7    <= nx7;
			b_s8    <= nx8;
			b_s9    <= nx9;
			out_s10 <= nx10;
		end
	end

	assign local_date.valid  = vld_q[NSTG-1];
	assign local_date.year   = out_s10.year;
	assign local_date.month  = out_s10.month;
	assign local_date.day    = out_s10.day;
	assign local_date.hour   = out_s10.hour;
	assign local_date.minute = out_s10.minute;

`ifndef SYNTHESIS
	a_doe_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] |-> (b_s1.doe <= LAST_DOE))
		else $error("back: day of era out of range");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NSTG-1] |-> (out_s10.month >= MONTH_W'(1) && out_s10.month <= MONTH_W'(12)
			&& out_s10.day >= DAY_W'(1) && out_s10.hour <= HOUR_W'(23)
			&& out_s10.minute <= MINUTE_W'(59)))
		else $error("back: date or time field out of range");

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NSTG-1] |-> (out_s10.year >= YEAR_W'(1970) && out_s10.year <= YEAR_W'(2106)))
		else $error("back: year out of range");
`endif

endmodule

`default_nettype wire

@@ design/unix_time_to_local_date_core.sv @@
// Top level of the Unix timestamp to UTC+8 calendar date and time converter.
`default_nettype none

// Each beat on stamp carries a 32-bit Unix time in seconds; each beat on local_date
// carries the matching local (UTC+8) year, month, day, hour and minute, one result per
// timestamp and in order. The offset sum wraps at 32 bits, so the last eight hours of
// the range map to the first eight hours of 1970. The block takes one timestamp every
// clock cycle while nothing stalls. A timestamp passes through the front stages (offset
// add, a reciprocal multiply for the day split and its correction), the queue and ten
// back stages, where every constant division is a reciprocal multiply followed by a
// one-step correction. While a result waits on local_date the back stages hold, and the
// queue of QUEUE_DEPTH beats lets the front keep taking timestamps until it fills.
module unix_time_to_local_date_core import utld_pkg::*; #(
	parameter int QUEUE_DEPTH = UTLD_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	utld_in_if.sink    stamp,
	utld_out_if.source local_date
);

	logic       push_valid;
	logic       push_ready;
	day_split_t push_data;
	logic       pop_valid;
	logic       pop_ready;
	day_split_t pop_data;

	utld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stamp      (stamp),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	utld_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	utld_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.local_date (local_date)
	);

endmodule

`default_nettype wire
